// File: design/mpfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfb_pkg
// types and constants shared by the page framebuffer blitter
// ----------------------------------------------------------------------------
package mpfb_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = 10;
  localparam int DEF_SCREEN_W = 128;
  localparam int DEF_SCREEN_H = 64;
  localparam logic [7:0] GRAY_EVEN = 8'b01010101;
  localparam logic [7:0] GRAY_ODD  = 8'b10101010;
  localparam logic [7:0] FULL_MASK = 8'hff;

  typedef enum logic [2:0] {
    CMD_PIXEL  = 3'd0,
    CMD_INVERT = 3'd1,
    CMD_GRAY   = 3'd2,
    CMD_FILL   = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_SET   = 2'd1,
    OP_XOR   = 2'd2,
    OP_GRAY  = 2'd3
  } op_t;

  // classified job handed from front to back; rows and columns already clipped
  typedef struct packed {
    logic       empty;   // nothing to write
    logic       is_read;
    op_t        op;
    logic [9:0] raddr;
    logic [8:0] x0;
    logic [8:0] x1;      // exclusive
    logic [8:0] y0;
    logic [8:0] y1;      // exclusive
  } job_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_RD,
    BK_WAIT,
    BK_WR,
    BK_OUT
  } bk_state_t;

endpackage

// File: design/mpfb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfb_front
// accepts commands, clips them and emits one job per command
// ----------------------------------------------------------------------------
module mpfb_front #(
  parameter int SCREEN_W = mpfb_pkg::DEF_SCREEN_W,
  parameter int SCREEN_H = mpfb_pkg::DEF_SCREEN_H
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        cmd,
  input  logic signed [8:0] pos_x,
  input  logic signed [8:0] pos_y,
  input  logic [7:0]        rect_w,
  input  logic [7:0]        rect_h,
  input  logic [1:0]        color,
  input  logic [9:0]        read_addr,
  output logic              job_valid,
  input  logic              job_stall,
  output mpfb_pkg::job_t    job
);
  import mpfb_pkg::*;

  localparam int PAGES = (SCREEN_H + 7) / 8;
  localparam int PAGE_H = PAGES * 8;

  job_t j;
  logic signed [10:0] ax0, ay0, ax1, ay1, cx0, cy0, cx1, cy1;
  logic signed [10:0] gh;
  logic               gray_empty;

  always_comb begin
    j = '0;
    j.raddr = read_addr;
    j.is_read = (cmd == CMD_READ);
    ax0 = 11'(pos_x);
    ay0 = 11'(pos_y);
    ax1 = ax0 + ((cmd == CMD_PIXEL) ? 11'sd1 : 11'($signed({1'b0, rect_w})));
    ay1 = ay0 + ((cmd == CMD_PIXEL) ? 11'sd1 : 11'($signed({1'b0, rect_h})));
    cx0 = (ax0 < 0) ? 11'sd0 : ax0;
    cy0 = (ay0 < 0) ? 11'sd0 : ay0;
    cx1 = (ax1 > 11'(SCREEN_W)) ? 11'(SCREEN_W) : ax1;
    cy1 = (ay1 > 11'(SCREEN_H)) ? 11'(SCREEN_H) : ay1;
    gh = ay1 - cy0;
    gray_empty = 1'b0;
    case (cmd)
      CMD_PIXEL:  j.op = (color >= 2'd2) ? OP_XOR : op_t'(color);
      CMD_INVERT: j.op = OP_XOR;
      CMD_FILL:   j.op = op_t'(color);
      CMD_GRAY:   j.op = OP_GRAY;
      default:    j.op = OP_CLEAR;
    endcase
    if (cmd == CMD_GRAY) begin
      // whole pages from the page of the clipped top row, limited to the screen pages
      cy1 = {cy0[10:3], 3'b000} + {gh[10:3], 3'b000};
      gray_empty = (gh[10:3] == 8'd0) || gh[10];
      cy0 = {cy0[10:3], 3'b000};
      if (cy1 > 11'(PAGE_H)) cy1 = 11'(PAGE_H);
      cx1 = (ax1 > 11'(SCREEN_W)) ? 11'(SCREEN_W) : ax1;
    end
    j.x0 = cx0[8:0];
    j.x1 = cx1[8:0];
    j.y0 = cy0[8:0];
    j.y1 = cy1[8:0];
    j.empty = (cx0 >= cx1) || (cy0 >= cy1) || gray_empty ||
              (cmd == CMD_FILL && color[1]) || (cmd > CMD_READ);
  end

  assign in_stall = job_valid && job_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (!in_stall) begin
      job_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      job <= j;
    end
  end

endmodule

// File: design/mpfb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfb_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module mpfb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_stall,
  input  mpfb_pkg::job_t wr_job,
  output logic           rd_valid,
  input  logic           rd_stall,
  output mpfb_pkg::job_t rd_job
);
  import mpfb_pkg::*;

  job_t       mem [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       push, pop;

  assign rd_valid = (count != 2'd0);
  assign wr_stall = (count == 2'd2);
  assign push = wr_valid && !wr_stall;
  assign pop  = rd_valid && !rd_stall;
  assign rd_job = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wr_job;
    end
  end

endmodule

// File: design/mpfb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfb_back
// walks a job over the framebuffer with read-modify-write, one byte at a time
// ----------------------------------------------------------------------------
module mpfb_back #(
  parameter int SCREEN_W = mpfb_pkg::DEF_SCREEN_W,
  parameter int SCREEN_H = mpfb_pkg::DEF_SCREEN_H
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_stall,
  input  mpfb_pkg::job_t job,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     read_data
);
  import mpfb_pkg::*;

  localparam int PAGES = (SCREEN_H + 7) / 8;
  localparam int USED  = (SCREEN_W * PAGES < STORE_DEPTH) ? SCREEN_W * PAGES : STORE_DEPTH;

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rdata;

  bk_state_t  state, state_next;
  job_t       cur;
  logic [8:0] col, col_next;
  logic [5:0] page, page_next;
  logic [ADDR_W-1:0] clr, clr_next;
  logic       take;
  logic [15:0] addr_full;
  logic [ADDR_W-1:0] addr;
  logic       in_range;
  logic [8:0] lo, hi;
  logic [7:0] mask, wdata;
  logic       we;
  logic [ADDR_W-1:0] waddr;
  logic       rd_en;
  logic [ADDR_W-1:0] raddr;
  logic       last_col, last_page;
  logic [7:0] out_data, out_data_next;

  assign addr_full = 16'(page) * 16'(SCREEN_W) + 16'(col);
  assign addr      = addr_full[ADDR_W-1:0];
  assign in_range  = (addr_full < 16'(USED));
  assign last_col  = (col + 9'd1 >= cur.x1);
  assign last_page = ({page + 6'd1, 3'b000} >= 9'(cur.y1)) || (page == 6'd63);

  always_comb begin
    lo = (cur.y0 > {page, 3'b000}) ? cur.y0 - {page, 3'b000} : 9'd0;
    hi = (cur.y1 < {page, 3'b000} + 9'd8) ? cur.y1 - {page, 3'b000} : 9'd8;
    mask = 8'((9'd1 << hi) - 9'd1) & ~8'((9'd1 << lo) - 9'd1);
    case (cur.op)
      OP_CLEAR: wdata = rdata & ~mask;
      OP_SET:   wdata = rdata | mask;
      OP_XOR:   wdata = rdata ^ mask;
      default:  wdata = ((col - cur.x0) & 9'd1) != 9'd0 ? GRAY_ODD : GRAY_EVEN;
    endcase
  end

  always_comb begin
    state_next = state;
    col_next = col;
    page_next = page;
    clr_next = clr;
    out_data_next = out_data;
    we = 1'b0;
    waddr = addr;
    rd_en = 1'b0;
    raddr = addr;
    take = 1'b0;
    case (state)
      BK_CLEAR: begin
        we = 1'b1;
        waddr = clr;
        clr_next = clr + 1'b1;
        if (clr == ADDR_W'(STORE_DEPTH - 1)) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        if (job_valid) begin
          take = 1'b1;
          col_next = job.x0;
          page_next = job.y0[8:3];
          out_data_next = 8'd0;
          if (job.is_read) begin
            rd_en = 1'b1;
            raddr = job.raddr;
            state_next = BK_WAIT;
          end else if (job.empty) begin
            state_next = BK_OUT;
          end else begin
            state_next = BK_RD;
          end
        end
      end
      BK_RD: begin
        rd_en = 1'b1;
        state_next = BK_WR;
      end
      BK_WAIT: begin
        out_data_next = rdata;
        state_next = BK_OUT;
      end
      BK_WR: begin
        we = in_range;
        if (last_col) begin
          col_next = cur.x0;
          page_next = page + 6'd1;
          state_next = last_page ? BK_OUT : BK_RD;
        end else begin
          col_next = col + 9'd1;
          state_next = BK_RD;
        end
      end
      BK_OUT: begin
        if (!out_stall) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  assign job_stall = !take;
  assign out_valid = (state == BK_OUT);
  assign read_data = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_CLEAR;
      clr <= '0;
    end else begin
      state <= state_next;
      clr <= clr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) cur <= job;
    col <= col_next;
    page <= page_next;
    out_data <= out_data_next;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= (state == BK_CLEAR) ? 8'd0 : wdata;
    if (rd_en) rdata <= mem[raddr];
  end

endmodule

// File: design/mono_page_framebuffer_raster_ops.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_page_framebuffer_raster_ops
// page-organized 1-bit framebuffer with pixel, rectangle and read commands
// ----------------------------------------------------------------------------
// commands enter on in_valid/in_stall, one result per command leaves on
// out_valid/out_stall; read_data carries the byte for a read, zero otherwise.
// the front clips each command and hands a job through a two-entry queue to
// the back, which walks the clipped area column by column and page by page
// with a read-modify-write on the single-port framebuffer memory: a read
// state, then a write state per byte touched. a read goes through a wait
// state to the result; an empty command goes straight to the result.
// after reset the back clears all 1024 bytes, one per cycle; commands are
// held in the front and queue until then.
// when out_stall is high the result is held and the back waits; the queue
// and front keep taking commands until they are full.
// ----------------------------------------------------------------------------
module mono_page_framebuffer_raster_ops #(
  parameter int SCREEN_W = mpfb_pkg::DEF_SCREEN_W,
  parameter int SCREEN_H = mpfb_pkg::DEF_SCREEN_H
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        cmd,
  input  logic signed [8:0] pos_x,
  input  logic signed [8:0] pos_y,
  input  logic [7:0]        rect_w,
  input  logic [7:0]        rect_h,
  input  logic [1:0]        color,
  input  logic [9:0]        read_addr,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        read_data
);
  import mpfb_pkg::*;

  logic f_valid, f_stall, q_valid, q_stall;
  job_t f_job, q_job;

  mpfb_front #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_front (
    .clk, .rst, .in_valid, .in_stall, .cmd, .pos_x, .pos_y, .rect_w, .rect_h,
    .color, .read_addr, .job_valid(f_valid), .job_stall(f_stall), .job(f_job)
  );

  mpfb_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_stall(f_stall), .wr_job(f_job),
    .rd_valid(q_valid), .rd_stall(q_stall), .rd_job(q_job)
  );

  mpfb_back #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_back (
    .clk, .rst, .job_valid(q_valid), .job_stall(q_stall), .job(q_job),
    .out_valid, .out_stall, .read_data
  );

  a_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data))
    else $error("result changed while stalled");

  a_queue_take: assert property (@(posedge clk) disable iff (rst)
    q_valid && !q_stall |-> !out_valid)
    else $error("job taken while result pending");

endmodule

// File: sim/mpfb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfb_checker
// watches the command and result channels of the page framebuffer blitter,
// keeps its own copy of the framebuffer, predicts each result byte and
// compares it against the returned byte in order
// ----------------------------------------------------------------------------
module mpfb_checker #(
  parameter int SCREEN_W = mpfb_pkg::DEF_SCREEN_W,
  parameter int SCREEN_H = mpfb_pkg::DEF_SCREEN_H
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [2:0]        cmd,
  input  logic signed [8:0] pos_x,
  input  logic signed [8:0] pos_y,
  input  logic [7:0]        rect_w,
  input  logic [7:0]        rect_h,
  input  logic [1:0]        color,
  input  logic [9:0]        read_addr,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [7:0]        read_data,
  output int                errors,
  output int                pending
);
  import mpfb_pkg::*;

  localparam int PAGES = (SCREEN_H + 7) / 8;
  localparam int USED = (SCREEN_W * PAGES < STORE_DEPTH) ? SCREEN_W * PAGES : STORE_DEPTH;

  logic [7:0] pixels [STORE_DEPTH];
  logic [7:0] expected_bytes[$];

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("mismatch %s: got %02h want %02h at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic put_byte(input int page, input int col, input logic [7:0] mask, input op_t op);
    int a;
    if (page < 0 || col < 0 || col >= SCREEN_W) return;
    a = page * SCREEN_W + col;
    if (a >= USED) return;
    case (op)
      OP_CLEAR: pixels[a] &= ~mask;
      OP_SET:   pixels[a] |= mask;
      default:  pixels[a] ^= mask;
    endcase
  endtask

  task automatic paint_rect(input int x, input int y, input int w, input int h, input op_t op);
    int x0, y0, x1, y1, lo, hi;
    logic [7:0] m;
    x0 = x < 0 ? 0 : x;
    y0 = y < 0 ? 0 : y;
    x1 = x + w > SCREEN_W ? SCREEN_W : x + w;
    y1 = y + h > SCREEN_H ? SCREEN_H : y + h;
    if (x0 >= x1 || y0 >= y1) return;
    for (int p = y0 / 8; p <= (y1 - 1) / 8; p++) begin
      lo = (y0 > p * 8 ? y0 : p * 8) - p * 8;
      hi = (y1 < p * 8 + 8 ? y1 : p * 8 + 8) - p * 8;
      m = 8'((9'(1) << hi) - 1) & ~8'((9'(1) << lo) - 1);
      for (int c = x0; c < x1; c++) put_byte(p, c, m, op);
    end
  endtask

  task automatic paint_gray(input int x, input int y, input int w, input int h);
    int p;
    if (y < 0) begin
      h += y;
      y = 0;
    end
    if (x < 0) begin
      w += x;
      x = 0;
    end
    if (w <= 0 || h <= 0) return;
    for (int k = 0; k < h / 8; k++) begin
      p = y / 8 + k;
      if (p >= PAGES) break;
      for (int j = 0; j < w && x + j < SCREEN_W; j++) begin
        put_byte(p, x + j, FULL_MASK, OP_CLEAR);
        put_byte(p, x + j, j[0] ? GRAY_ODD : GRAY_EVEN, OP_SET);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (pixels[i]) pixels[i] = '0;
      expected_bytes.delete();
      errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) report("unexpected result", read_data, 8'h00);
        else if (read_data !== expected_bytes[0]) report("read_data", read_data, expected_bytes.pop_front());
        else void'(expected_bytes.pop_front());
      end
      if (in_valid && !in_stall) begin
        logic [7:0] byte_out;
        byte_out = '0;
        case (cmd)
          CMD_PIXEL:  paint_rect(pos_x, pos_y, 1, 1, color >= 2 ? OP_XOR : op_t'(color));
          CMD_INVERT: paint_rect(pos_x, pos_y, rect_w, rect_h, OP_XOR);
          CMD_GRAY:   paint_gray(pos_x, pos_y, rect_w, rect_h);
          CMD_FILL:   if (color <= 1) paint_rect(pos_x, pos_y, rect_w, rect_h, op_t'(color));
          CMD_READ:   byte_out = pixels[read_addr];
          default:    ;
        endcase
        expected_bytes.push_back(byte_out);
      end
    end
    pending = expected_bytes.size();
  end

endmodule

// File: sim/tb_mono_page_framebuffer_raster_ops.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mono_page_framebuffer_raster_ops
// drives directed and random drawing commands with reads interleaved, with
// random idle bursts on both channels; a checker predicts every result byte
// ----------------------------------------------------------------------------
module tb_mono_page_framebuffer_raster_ops;
  import mpfb_pkg::*;

  localparam int ITEMS = 526;
  localparam int WATCHDOG = 40000;

  logic clk, rst, in_valid, in_stall, out_valid, out_stall;
  logic [2:0] cmd;
  logic signed [8:0] pos_x, pos_y;
  logic [7:0] rect_w, rect_h, read_data;
  logic [1:0] color;
  logic [9:0] read_addr;
  int errors, pending, quiet, sent;
  bit calm;

  mono_page_framebuffer_raster_ops dut (.*);

  mpfb_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver stall bursts
  initial begin
    int n;
    out_stall = 0;
    forever begin
      n = $urandom_range(1, 13);
      repeat (n) @(posedge clk);
      out_stall <= !calm && $urandom_range(0, 2) == 0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send(input logic [2:0] c, input int x, input int y, input int w, input int h,
                      input int col, input int a);
    cmd <= c;
    pos_x <= 9'(x);
    pos_y <= 9'(y);
    rect_w <= 8'(w);
    rect_h <= 8'(h);
    color <= 2'(col);
    read_addr <= 10'(a);
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic random_cmd();
    int c, big;
    c = $urandom_range(0, 9);
    big = $urandom_range(0, 15) == 0;
    if (c >= 5 && c <= 8) begin
      send(CMD_READ, 0, 0, 0, 0, $urandom, $urandom_range(0, 1023));
    end else begin
      send(c == 9 ? 3'($urandom_range(5, 7)) : 3'(c),
           $urandom_range(0, 7) == 0 ? $urandom_range(0, 511) - 256 : $urandom_range(0, 140) - 8,
           $urandom_range(0, 7) == 0 ? $urandom_range(0, 511) - 256 : $urandom_range(0, 72) - 8,
           big ? $urandom_range(0, 255) : $urandom_range(0, 20),
           big ? $urandom_range(0, 255) : $urandom_range(0, 20),
           $urandom_range(0, 3), $urandom_range(0, 1023));
    end
  endtask

  initial begin
    calm = 0;
    sent = 0;
    in_valid = 0;
    cmd = '0;
    pos_x = '0;
    pos_y = '0;
    rect_w = '0;
    rect_h = '0;
    color = '0;
    read_addr = '0;
    rst = 1;
    repeat (4) @(posedge clk);
    rst <= 0;
    send(CMD_READ, 0, 0, 0, 0, 0, 0);
    send(CMD_PIXEL, 0, 0, 0, 0, 1, 0);
    send(CMD_PIXEL, 127, 63, 0, 0, 3, 0);
    send(CMD_PIXEL, -256, 255, 0, 0, 2, 0);
    send(CMD_READ, 0, 0, 0, 0, 0, 0);
    send(CMD_READ, 0, 0, 0, 0, 0, 1023);
    send(CMD_READ, 0, 0, 0, 0, 0, 7 * 128 + 127);
    send(CMD_INVERT, 3, 2, 5, 3, 0, 0);
    send(CMD_INVERT, -256, -256, 255, 255, 0, 0);
    send(CMD_INVERT, 10, 10, 0, 5, 0, 0);
    send(CMD_GRAY, -3, -4, 20, 21, 0, 0);
    send(CMD_GRAY, 120, 56, 255, 255, 0, 0);
    send(CMD_FILL, 5, 5, 30, 20, 1, 0);
    send(CMD_FILL, 8, 9, 7, 3, 0, 0);
    send(CMD_FILL, 0, 0, 50, 50, 2, 0);
    send(CMD_FILL, 255, 255, 255, 255, 3, 0);
    send(3'd5, 0, 0, 0, 0, 0, 0);
    send(3'd7, -1, -1, 255, 255, 3, 1023);
    for (int a = 0; a < 8; a++) send(CMD_READ, 0, 0, 0, 0, 0, 128 * a + 5);
    in_valid <= 0;
    do @(posedge clk); while (pending != 0);
    for (int i = 0; i < ITEMS; i++) begin
      if (i == ITEMS - 60) calm = 1;
      random_cmd();
    end
    for (int a = 0; a < 1024; a += 37) send(CMD_READ, 0, 0, 0, 0, 0, a);
    in_valid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// File: mono_page_framebuffer_raster_ops.f
design/mpfb_pkg.sv
design/mpfb_front.sv
design/mpfb_queue.sv
design/mpfb_back.sv
design/mono_page_framebuffer_raster_ops.sv
sim/mpfb_checker.sv
sim/tb_mono_page_framebuffer_raster_ops.sv
